// File: design/masked_byte_pattern_search_assert.svh
// Assertion macros for the masked byte pattern search block
`ifndef MASKED_BYTE_PATTERN_SEARCH_ASSERT_SVH
`define MASKED_BYTE_PATTERN_SEARCH_ASSERT_SVH

// same-cycle implication, disabled while reset is held
`define MBPS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is held
`define MBPS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/mbps_pkg.sv
// Package: types and constants of the masked byte pattern search block
package mbps_pkg;

    localparam int MAX_PATTERN_DEF = 16;
    localparam int COUNT_BITS_DEF  = 32;

    localparam int PAT_BYTES  = 16;   // pattern register holds 16 bytes
    localparam int PAT_IDX_W  = 4;
    localparam int LEN_CFG_W  = 5;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 64;
    localparam int ADDR_W     = 64;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PATTERN_LOW    = 4'd0,
        REG_PATTERN_HIGH   = 4'd1,
        REG_CARE_MASK      = 4'd2,
        REG_PATTERN_LENGTH = 4'd3,
        REG_IMAGE_BASE     = 4'd4,
        REG_PATTERN_OFFSET = 4'd5,
        REG_ADDRESS_OFFSET = 4'd6,
        REG_SUBTRACT_BASE  = 4'd7
    } t_cfg_reg;

    // per-cell compare setup
    typedef struct packed {
        logic       care;
        logic [7:0] expect_byte;
    } t_cell_cfg;

    // address terms handed to the result stage
    typedef struct packed {
        logic              subtract_base;
        logic [ADDR_W-1:0] image_base;
        logic [ADDR_W-1:0] match_off;
        logic [ADDR_W-1:0] report_off;
    } t_addr_cfg;

endpackage

// File: design/mbps_if.sv
// Interfaces: byte stream, result stream and configuration write channel
interface mbps_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] image_byte;
    logic       last_byte;
    modport source (output valid, output image_byte, output last_byte, input ready);
    modport sink   (input valid, input image_byte, input last_byte, output ready);
endinterface

interface mbps_res_if;
    logic                        valid;
    logic                        ready;
    logic                        found;
    logic [mbps_pkg::ADDR_W-1:0] result_address;
    modport source (output valid, output found, output result_address, input ready);
    modport sink   (input valid, input found, input result_address, output ready);
endinterface

interface mbps_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [mbps_pkg::CFG_IDX_W-1:0]  index;
    logic [mbps_pkg::CFG_DATA_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: design/mbps_cell.sv
// Window cell: holds one image byte, passes it on, compares the incoming byte
module mbps_cell (
    input  logic                i_clk,
    input  logic                i_shift,
    input  logic [7:0]          i_byte,
    input  mbps_pkg::t_cell_cfg i_cfg,
    output logic [7:0]          o_byte,
    output logic                o_ok
);

    logic [7:0] r_byte;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_byte <= i_byte;
        end
    end

    // compare the byte this cell takes on the shift (window after the shift)
    assign o_ok   = !i_cfg.care || (i_byte == i_cfg.expect_byte);
    assign o_byte = r_byte;

endmodule

// File: design/mbps_result.sv
// Result pipeline: hit register, address add and output register
module mbps_result #(
    parameter int COUNT_BITS = mbps_pkg::COUNT_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic                i_found,
    input  logic [COUNT_BITS-1:0] i_offset,
    input  mbps_pkg::t_addr_cfg i_addr_cfg,
    output logic                o_ready,
    mbps_res_if.source          o_res
);

    localparam int AW = mbps_pkg::ADDR_W;

    logic                  r_a_valid;
    logic                  r_a_found;
    logic [COUNT_BITS-1:0] r_a_offset;
    logic [AW-1:0]         r_k;
    logic [AW-1:0]         n_k;
    logic                  r_o_valid;
    logic                  r_o_found;
    logic [AW-1:0]         r_o_addr;
    logic                  w_adv_b;

    // constant part of the address; the user must keep config quiet while items flow, the block does not enforce it
    always_comb begin
        n_k = i_addr_cfg.match_off + i_addr_cfg.report_off;
        if (!i_addr_cfg.subtract_base) begin
            n_k = n_k + i_addr_cfg.image_base;
        end
    end

    always_ff @(posedge i_clk) begin
        r_k <= n_k;
    end

    assign w_adv_b = !r_o_valid || o_res.ready;
    assign o_ready = !r_a_valid || w_adv_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (o_ready) begin
                r_a_valid <= i_valid;
            end
            if (w_adv_b) begin
                r_o_valid <= r_a_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_a_found  <= i_found;
            r_a_offset <= i_offset;
        end
        if (w_adv_b && r_a_valid) begin
            r_o_found <= r_a_found;
            r_o_addr  <= r_a_found ? (AW'(r_a_offset) + r_k) : '0;
        end
    end

    assign o_res.valid          = r_o_valid;
    assign o_res.found          = r_o_found;
    assign o_res.result_address = r_o_addr;

endmodule

// File: design/masked_byte_pattern_search.sv
// Top level: masked byte pattern search over a streamed memory image
// - i_byte: image bytes in address order, one word per byte; last_byte marks
//   the final byte. i_cfg: register writes (index, data), always ready; write
//   only while the block is idle.
// - o_res: at most one word per image. found=1 with the match address on the
//   first window that matches; found=0 and address 0 if the image ends first.
//   Bytes after a match are taken and dropped until last_byte.
// - Throughput: one byte per cycle while the result pipe has room. The
//   window is a chain of MAX_PATTERN cells that shift on each accepted
//   byte and compare in parallel. Result path: the hit register, then the
//   address add into the output register that drives o_res.valid.
// - Stall: while o_res is held off the two result stages fill; i_byte.ready
//   drops only once both hold a word. Bytes that give no result still need
//   ready, so a full result pipe halts the byte stream.
// - Reset (i_rst_n low, synchronous): registers take their defaults (care
//   mask all ones, length 1, the rest zero), counters and pipe valids clear.
//   No clearing pass; the block is ready the cycle after reset.
// - Address = image base + offset + pattern offset (less the image base when
//   subtract_base is set) + address offset, wrapping at 64 bits.
`include "masked_byte_pattern_search_assert.svh"
module masked_byte_pattern_search #(
    parameter int MAX_PATTERN = mbps_pkg::MAX_PATTERN_DEF,
    parameter int COUNT_BITS  = mbps_pkg::COUNT_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mbps_byte_if.sink   i_byte,
    mbps_cfg_if.sink    i_cfg,
    mbps_res_if.source  o_res
);

    localparam int LW = $clog2(MAX_PATTERN + 1);
    localparam int PB = mbps_pkg::PAT_BYTES;
    localparam int LCW = mbps_pkg::LEN_CFG_W;

    // configuration registers
    logic [63:0]    r_pat_low;
    logic [63:0]    r_pat_high;
    logic [PB-1:0]  r_care;
    logic [LCW-1:0] r_pat_len;
    logic [63:0]    r_base;
    logic [63:0]    r_pat_off;
    logic [63:0]    r_addr_off;
    logic           r_sub_base;

    // image state
    logic [COUNT_BITS-1:0] r_seen;
    logic                  r_done;

    logic                  w_accept;
    logic                  w_cfg_wr;
    logic [LW-1:0]         w_len;
    logic [7:0]            w_pat_bytes [PB];
    logic [7:0]            w_chain [MAX_PATTERN];
    logic [MAX_PATTERN-1:0] w_ok;
    mbps_pkg::t_cell_cfg   w_cell_cfg [MAX_PATTERN];
    logic [COUNT_BITS-1:0] w_seen_n;
    logic                  w_step;
    logic                  w_hit;
    logic                  w_res;
    logic [COUNT_BITS-1:0] w_offset;
    logic                  w_res_rdy;
    mbps_pkg::t_addr_cfg   w_addr_cfg;

    assign w_accept    = i_byte.valid && i_byte.ready;
    assign i_cfg.ready = 1'b1;
    assign w_cfg_wr    = i_cfg.valid && i_cfg.ready;

    // ---- configuration write port ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_low  <= '0;
            r_pat_high <= '0;
            r_care     <= '1;
            r_pat_len  <= LCW'(1);
            r_base     <= '0;
            r_pat_off  <= '0;
            r_addr_off <= '0;
            r_sub_base <= 1'b0;
        end else if (w_cfg_wr) begin
            unique case (i_cfg.index)
                mbps_pkg::REG_PATTERN_LOW:    r_pat_low  <= i_cfg.data;
                mbps_pkg::REG_PATTERN_HIGH:   r_pat_high <= i_cfg.data;
                mbps_pkg::REG_CARE_MASK:      r_care     <= i_cfg.data[PB-1:0];
                mbps_pkg::REG_PATTERN_LENGTH: r_pat_len  <= i_cfg.data[LCW-1:0];
                mbps_pkg::REG_IMAGE_BASE:     r_base     <= i_cfg.data;
                mbps_pkg::REG_PATTERN_OFFSET: r_pat_off  <= i_cfg.data;
                mbps_pkg::REG_ADDRESS_OFFSET: r_addr_off <= i_cfg.data;
                mbps_pkg::REG_SUBTRACT_BASE:  r_sub_base <= i_cfg.data[0];
                default: ; // indexes past the list are ignored
            endcase
        end
    end

    // length in use: zero acts as one, clamp at the window depth
    always_comb begin
        if (r_pat_len == '0) begin
            w_len = LW'(1);
        end else if (r_pat_len > LCW'(MAX_PATTERN)) begin
            w_len = LW'(MAX_PATTERN);
        end else begin
            w_len = LW'(r_pat_len);
        end
    end

    always_comb begin
        for (int i = 0; i < 8; i++) begin
            w_pat_bytes[i]     = r_pat_low[8*i +: 8];
            w_pat_bytes[i + 8] = r_pat_high[8*i +: 8];
        end
    end

    // ---- cell chain: cell a holds the byte taken a words ago ----
    // it faces pattern byte len-1-a, and only cares while a < len
    genvar a;
    generate
        for (a = 0; a < MAX_PATTERN; a++) begin : g_cell
            logic [LCW-1:0] w_k;
            logic [7:0]     w_in;

            assign w_k = LCW'(w_len) - LCW'(a) - LCW'(1);
            assign w_cell_cfg[a].care =
                (LCW'(a) < LCW'(w_len)) && r_care[w_k[mbps_pkg::PAT_IDX_W-1:0]];
            assign w_cell_cfg[a].expect_byte = w_pat_bytes[w_k[mbps_pkg::PAT_IDX_W-1:0]];

            if (a == 0) begin : g_head
                assign w_in = i_byte.image_byte;
            end else begin : g_link
                assign w_in = w_chain[a-1];
            end

            mbps_cell u_cell (
                .i_clk   (i_clk),
                .i_shift (w_accept),
                .i_byte  (w_in),
                .i_cfg   (w_cell_cfg[a]),
                .o_byte  (w_chain[a]),
                .o_ok    (w_ok[a])
            );
        end
    endgenerate

    // ---- byte count and hit decision ----
    assign w_step   = !r_done && (r_seen != '1);   // counter saturates
    assign w_seen_n = r_seen + COUNT_BITS'(1);
    assign w_hit    = w_step && (w_seen_n >= COUNT_BITS'(w_len)) && (&w_ok);
    assign w_offset = w_seen_n - COUNT_BITS'(w_len);
    assign w_res    = w_hit || (i_byte.last_byte && !r_done);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= '0;
            r_done <= 1'b0;
        end else if (w_accept) begin
            if (i_byte.last_byte) begin
                r_seen <= '0;
                r_done <= 1'b0;
            end else if (w_step) begin
                r_seen <= w_seen_n;
                if (w_hit) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign i_byte.ready = w_res_rdy;

    assign w_addr_cfg.subtract_base = r_sub_base;
    assign w_addr_cfg.image_base    = r_base;
    assign w_addr_cfg.match_off     = r_pat_off;
    assign w_addr_cfg.report_off    = r_addr_off;

    mbps_result #(
        .COUNT_BITS (COUNT_BITS)
    ) u_result (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (w_accept && w_res),
        .i_found    (w_hit),
        .i_offset   (w_offset),
        .i_addr_cfg (w_addr_cfg),
        .o_ready    (w_res_rdy),
        .o_res      (o_res)
    );

    // ---- checks ----
    `MBPS_ASSERT_NOW(a_nf_zero, i_clk, i_rst_n, o_res.valid && !o_res.found, o_res.result_address == '0, "not-found word with nonzero address")
    `MBPS_ASSERT_NEXT(a_last_clears, i_clk, i_rst_n, w_accept && i_byte.last_byte, (r_seen == '0) && !r_done, "image state not cleared after last byte")
    `MBPS_ASSERT_NEXT(a_count_mono, i_clk, i_rst_n, w_accept && !i_byte.last_byte, r_seen >= $past(r_seen), "byte count went backwards inside an image")

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 100ps
// Testbench for masked_byte_pattern_search: search tracker class, drive tasks and top module
import mbps_pkg::*;

typedef struct {
    bit              found;
    bit [ADDR_W-1:0] addr;
} search_outcome_t;

// Shadow copy of the search: registers, byte window and outcomes still owed
class search_tracker;
    bit [63:0]       pat_lo, pat_hi, img_base, pat_off, addr_off;
    bit [15:0]       care;
    bit [4:0]        len_cfg;
    bit              sub_base;
    bit [7:0]        window [PAT_BYTES];
    longint unsigned seen;
    bit              matched;
    search_outcome_t pending [$];
    int              errors;

    function new();
        pat_lo   = '0;
        pat_hi   = '0;
        img_base = '0;
        pat_off  = '0;
        addr_off = '0;
        care     = '1;
        len_cfg  = 5'd1;
        sub_base = 1'b0;
        errors   = 0;
        clear_image();
    endfunction

    function void clear_image();
        foreach (window[k]) window[k] = '0;
        seen    = 0;
        matched = 1'b0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
        case (idx)
            REG_PATTERN_LOW:    pat_lo   = v;
            REG_PATTERN_HIGH:   pat_hi   = v;
            REG_CARE_MASK:      care     = v[15:0];
            REG_PATTERN_LENGTH: len_cfg  = v[LEN_CFG_W-1:0];
            REG_IMAGE_BASE:     img_base = v;
            REG_PATTERN_OFFSET: pat_off  = v;
            REG_ADDRESS_OFFSET: addr_off = v;
            REG_SUBTRACT_BASE:  sub_base = v[0];
            default: ;
        endcase
    endfunction

    // zero acts as one, anything past the window as the full window
    function int unsigned eff_len();
        if (len_cfg == 0) return 1;
        if (len_cfg > MAX_PATTERN_DEF) return MAX_PATTERN_DEF;
        return len_cfg;
    endfunction

    function bit [7:0] pat_byte(int unsigned k);
        return (k < 8) ? pat_lo[8*k +: 8] : pat_hi[8*(k-8) +: 8];
    endfunction

    function bit window_hit(int unsigned len);
        for (int unsigned k = 0; k < len; k++)
            if (care[k] && window[PAT_BYTES - len + k] != pat_byte(k)) return 1'b0;
        return 1'b1;
    endfunction

    function void note_byte(bit [7:0] b, bit last);
        int unsigned     len;
        bit [63:0]       a;
        search_outcome_t hit;
        for (int k = 0; k < PAT_BYTES - 1; k++) window[k] = window[k+1];
        window[PAT_BYTES-1] = b;
        len = eff_len();
        if (!matched && seen < ((64'd1 << COUNT_BITS_DEF) - 1)) begin
            seen++;
            if (seen >= len && window_hit(len)) begin
                a = img_base + (seen - len) + pat_off;
                if (sub_base) a -= img_base;
                hit.found = 1'b1;
                hit.addr  = a + addr_off;
                pending.push_back(hit);
                matched = 1'b1;
            end
        end
        if (last) begin
            if (!matched) begin
                hit.found = 1'b0;
                hit.addr  = '0;
                pending.push_back(hit);
            end
            clear_image();
        end
    endfunction

    function void check_result(bit f, bit [63:0] a);
        search_outcome_t want;
        if (pending.size() == 0) begin
            errors++;
            $display("%0t: unexpected word: expected none, got found=%0b addr=%h", $time, f, a);
            return;
        end
        want = pending.pop_front();
        if (want.found != f) begin
            errors++;
            $display("%0t: found mismatch: expected %0b, got %0b", $time, want.found, f);
        end
        if (want.addr != a) begin
            errors++;
            $display("%0t: address mismatch: expected %h, got %h", $time, want.addr, a);
        end
    endfunction
endclass

module tb_top;

    localparam int HALF_PERIOD     = 4;
    localparam int RESET_CYCLES    = 6;
    localparam int STALL_LIMIT     = 4000;  // cycles with no word moving on any channel
    localparam int SETTLE_CYCLES   = 4;     // result pipe is two stages deep
    localparam int NUM_PHASES      = 6;
    localparam int PHASE_BYTES     = 75;
    localparam int HOLD_PHASE      = 4;
    localparam int PAUSE_PHASE     = 2;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int REG_COUNT       = int'(REG_SUBTRACT_BASE) + 1;

    logic i_clk;
    logic i_rst_n;

    mbps_byte_if byte_if ();
    mbps_res_if  res_if ();
    mbps_cfg_if  cfg_if ();

    masked_byte_pattern_search dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_byte  (byte_if),
        .i_cfg   (cfg_if),
        .o_res   (res_if)
    );

    search_tracker tracker;

    int       send_idle_pct = 0;   // chance per cycle that the byte sender holds back
    int       stall_pct     = 0;   // chance per cycle that the result side is not ready
    int       hold_request  = 0;   // long receiver hold-off, picked up by the receiver
    int       quiet_cycles  = 0;
    int       bytes_sent    = 0;
    bit [7:0] image_q [$];

    initial i_clk = 1'b0;
    always #(HALF_PERIOD) i_clk = ~i_clk;

    function automatic bit [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // ---------------------------------------------------------------
    // Drive tasks: all run from the falling edge and return on one
    // ---------------------------------------------------------------

    // one image byte; valid stays high into the next byte unless it idles
    task automatic send_byte(input bit [7:0] b, input bit last);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            byte_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        byte_if.valid      <= 1'b1;
        byte_if.image_byte <= b;
        byte_if.last_byte  <= last;
        @(posedge i_clk);
        while (!byte_if.ready) @(posedge i_clk);
        tracker.note_byte(b, last);
        bytes_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_image();
        foreach (image_q[k]) send_byte(image_q[k], k == image_q.size() - 1);
    endtask

    // leaves valid high so back-to-back writes need no lowering
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] v);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= v;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        tracker.write_reg(idx, v);
        @(negedge i_clk);
    endtask

    // full register set; narrow registers get junk in their unused upper bits
    task automatic set_search_regs(input bit [63:0] lo, hi, input bit [15:0] mask,
                                   input bit [4:0] len, input bit [63:0] base, poff, aoff,
                                   input bit sub);
        bit [63:0] junk;
        junk = rand64();
        cfg_write(REG_PATTERN_LOW, lo);
        cfg_write(REG_PATTERN_HIGH, hi);
        cfg_write(REG_CARE_MASK, {junk[63:16], mask});
        cfg_write(REG_PATTERN_LENGTH, {junk[63:5], len});
        cfg_write(REG_IMAGE_BASE, base);
        cfg_write(REG_PATTERN_OFFSET, poff);
        cfg_write(REG_ADDRESS_OFFSET, aoff);
        cfg_write(REG_SUBTRACT_BASE, {junk[63:1], sub});
        cfg_if.valid <= 1'b0;
    endtask

    // stop offering bytes until every owed word is in, then let the pipe settle
    task automatic drain_results();
        byte_if.valid <= 1'b0;
        while (tracker.pending.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Random image shaped against the live pattern. Most images carry the
    // pattern (cared bytes exact, wildcards random) after a random lead, usually short,
    // sometimes ending right on the match; some carry it with one bit flipped,
    // some are shorter than the pattern, the rest are plain noise.
    task automatic build_image();
        int unsigned len, kind, lead, tail, flip, n;
        bit [7:0]    b;
        image_q.delete();
        len  = tracker.eff_len();
        kind = $urandom_range(0, 9);
        lead = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 120) : $urandom_range(0, 6);
        tail = $urandom_range(0, 1) ? 0 : $urandom_range(1, 6);
        if (kind <= 7) begin
            flip = (kind == 7) ? $urandom_range(0, len - 1) : len;
            repeat (lead) image_q.push_back(8'($urandom));
            for (int unsigned k = 0; k < len; k++) begin
                b = tracker.care[k] ? tracker.pat_byte(k) : 8'($urandom);
                if (k == flip) b = b ^ (8'd1 << $urandom_range(0, 7));
                image_q.push_back(b);
            end
            repeat (tail) image_q.push_back(8'($urandom));
        end else begin
            n = (kind == 8 && len > 1) ? $urandom_range(1, len - 1) : $urandom_range(1, 24);
            repeat (n) image_q.push_back(8'($urandom));
        end
    endtask

    // register setting and handshake pressure for each random phase
    task automatic configure_phase(input int p);
        case (p)
            0: begin
                set_search_regs(rand64(), rand64(), 16'($urandom), 5'($urandom_range(4, 8)),
                                rand64(), rand64(), rand64(), 1'($urandom_range(0, 1)));
                send_idle_pct = 0;
                stall_pct     = 0;
            end
            1: begin
                // everything at its top value: full window, address sums wrap
                set_search_regs('1, '1, '1, 5'd16, '1, '1, '1, 1'b1);
                send_idle_pct = 80;
                stall_pct     = 0;
            end
            2: begin
                // all zero: length zero acts as one, no byte cared about
                set_search_regs('0, '0, '0, 5'd0, '0, '0, '0, 1'b0);
                send_idle_pct = 0;
                stall_pct     = 80;
            end
            3: begin
                // length beyond the window clips to the full window
                set_search_regs(rand64(), rand64(), 16'($urandom), 5'($urandom_range(17, 31)),
                                rand64(), rand64(), rand64(), 1'($urandom_range(0, 1)));
                send_idle_pct = 22;
                stall_pct     = 22;
            end
            4: begin
                set_search_regs(rand64(), rand64(), 16'($urandom), 5'($urandom_range(1, 16)),
                                rand64(), rand64(), rand64(), 1'($urandom_range(0, 1)));
                send_idle_pct = 0;
                stall_pct     = 0;
            end
            default: begin
                // a write to an unmapped index must leave the search alone
                cfg_write(CFG_IDX_W'($urandom_range(REG_COUNT, (1 << CFG_IDX_W) - 1)),
                          rand64());
                set_search_regs(rand64(), rand64(), 16'($urandom), 5'($urandom_range(0, 31)),
                                rand64(), rand64(), rand64(), 1'($urandom_range(0, 1)));
                send_idle_pct = 22;
                stall_pct     = 22;
            end
        endcase
    endtask

    // ---------------------------------------------------------------
    // Result side: ready changes on the falling edge; a long hold-off
    // request overrides the random stalls for its whole length
    // ---------------------------------------------------------------
    initial begin
        int hold_left;
        hold_left    = 0;
        res_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request > 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid && res_if.ready)
            tracker.check_result(res_if.found, res_if.result_address);
    end

    // Watchdog: a run that stops moving words is a hang
    always @(posedge i_clk) begin
        if ((byte_if.valid && byte_if.ready) || (res_if.valid && res_if.ready) ||
            (cfg_if.valid && cfg_if.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------
    initial begin
        int phase_start;
        bit paused;
        tracker            = new();
        paused             = 1'b0;
        i_rst_n            = 1'b0;
        byte_if.valid      = 1'b0;
        byte_if.image_byte = '0;
        byte_if.last_byte  = 1'b0;
        cfg_if.valid       = 1'b0;
        cfg_if.index       = '0;
        cfg_if.data        = '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset defaults: zero pattern, length one, every byte cared about,
        // so a lone zero byte hits at address zero and a lone 0xFF misses
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);
        drain_results();

        // Pattern FF 00 ?? 3F with junk above the length and in the mask
        set_search_regs(64'hA5A5_A5A5_3F5A_00FF, '1, 16'hFFFB, 5'd4,
                        64'h1000, 64'h20, 64'h7, 1'b0);
        image_q = '{8'hFF, 8'h00};                     // shorter than the pattern
        send_image();
        image_q = '{8'hFF, 8'h00, 8'h12, 8'h3F};       // hit on the final byte
        send_image();
        image_q = '{8'h55, 8'hFF, 8'h00, 8'hAA, 8'h3F, 8'h00, 8'hFF};  // later bytes dropped
        send_image();
        image_q = '{8'h80};                            // single byte, miss
        send_image();
        drain_results();

        for (int p = 0; p < NUM_PHASES; p++) begin
            configure_phase(p);
            // keep offering bytes while results are held back so the pipe fills
            if (p == HOLD_PHASE) hold_request = HOLD_OFF_CYCLES;
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < PHASE_BYTES) begin
                build_image();
                send_image();
                if (p == PAUSE_PHASE && !paused &&
                    bytes_sent - phase_start >= PHASE_BYTES / 2) begin
                    drain_results();
                    paused = 1'b1;
                end
            end
            drain_results();
        end

        if (tracker.errors == 0 && tracker.pending.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
